>>> rtl/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  localparam int VIRTUAL_PAGES = 32;
  localparam int MAX_FRAMES    = 32;

  localparam int PAGE_W  = 5;
  localparam int FRAME_W = 5;
  localparam int COUNT_W = 6;
  localparam int FAULT_W = 16;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] FRAME_COUNT_MAX   = COUNT_W'(MAX_FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX         = {FAULT_W{1'b1}};

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/fpr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpr_req_if import fpr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);

endinterface

`default_nettype wire

>>> rtl/fpr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpr_rsp_if import fpr_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_count;

  modport source (
    output valid, output hit, output frame, output evicted_valid,
    output evicted_page, output fault_count, input ready
  );
  modport sink (
    input valid, input hit, input frame, input evicted_valid,
    input evicted_page, input fault_count, output ready
  );

endinterface

`default_nettype wire

>>> rtl/fifo_page_replacement.sv
// fifo page replacement unit
// req carries one virtual page number per request (valid/ready); rsp returns
// one result per request: hit flag, frame now holding the page, the evicted
// page if any and the saturating fault count.
// cfg_wr_en/cfg_wr_data write the frame count (1..32, 0 acts as 1, larger
// values act as 32); a write also clears the page table, the round-robin
// pointer and the fault count. Write it only while no request is in flight.
// Flow: an accepted request and its page table and owner reads are registered,
// the lookup runs in ST_LOOKUP, and its result goes to the output register.
// Requests do not overlap: req is ready only in ST_IDLE, as the page table and
// owner memories are read before the write-back of the same request.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if rsp stalls, the lookup holds until the output
// register frees and req stays not ready meanwhile.
// Reset: synchronous, frame count 4, all pages non-resident, count zero.
`timescale 1ns / 1ps
`default_nettype none

module fifo_page_replacement import fpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  fpr_req_if.sink            req,
  fpr_rsp_if.source          rsp
);

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]       frame_count;
  logic [COUNT_W-1:0]       n_frames;
  logic [VIRTUAL_PAGES-1:0] page_valid;
  logic [FRAME_W-1:0]       next_frame;
  logic [COUNT_W-1:0]       frames_used;
  logic [FAULT_W-1:0]       faults;

  logic [FRAME_W-1:0] page_frame_mem [VIRTUAL_PAGES];
  logic [PAGE_W-1:0]  frame_owner_mem [MAX_FRAMES];
  logic [FRAME_W-1:0] page_frame_rd;
  logic [PAGE_W-1:0]  owner_rd;
  logic [PAGE_W-1:0]  page;

  logic               accept;
  logic               step;
  logic               hit_now;
  logic               full;
  logic               evict;
  logic [FRAME_W-1:0] alloc_frame;
  logic [FRAME_W-1:0] res_frame;
  logic [FAULT_W-1:0] faults_inc;
  logic [FRAME_W-1:0] next_frame_inc;

  assign accept = req.valid && req.ready;

  always_comb begin
    if (frame_count == '0) begin
      n_frames = COUNT_W'(1);
    end else if (frame_count > FRAME_COUNT_MAX) begin
      n_frames = FRAME_COUNT_MAX;
    end else begin
      n_frames = frame_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    step       = 1'b0;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!rsp.valid || rsp.ready) begin
          step       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // lookup and replacement decision
  always_comb begin
    hit_now     = page_valid[page];
    full        = frames_used >= n_frames;
    alloc_frame = full ? next_frame : frames_used[FRAME_W-1:0];
    res_frame   = hit_now ? page_frame_rd : alloc_frame;
    evict       = !hit_now && full;
    faults_inc  = (faults != FAULT_MAX) ? faults + FAULT_W'(1) : faults;
    if (({1'b0, next_frame} + COUNT_W'(1)) == n_frames) begin
      next_frame_inc = '0;
    end else begin
      next_frame_inc = next_frame + FRAME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page          <= req.page_number;
      page_frame_rd <= page_frame_mem[req.page_number];
    end
    if (step && !hit_now) begin
      page_frame_mem[page] <= alloc_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      owner_rd <= frame_owner_mem[next_frame];
    end
    if (step && !hit_now) begin
      frame_owner_mem[alloc_frame] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      page_valid  <= '0;
      next_frame  <= '0;
      frames_used <= '0;
      faults      <= '0;
    end else if (cfg_wr_en) begin
      frame_count <= cfg_wr_data;
      page_valid  <= '0;
      next_frame  <= '0;
      frames_used <= '0;
      faults      <= '0;
    end else if (step && !hit_now) begin
      faults <= faults_inc;
      if (full) begin
        next_frame           <= next_frame_inc;
        page_valid[owner_rd] <= 1'b0;
      end else begin
        frames_used <= frames_used + COUNT_W'(1);
      end
      page_valid[page] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (step) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.hit           <= hit_now;
      rsp.frame         <= res_frame;
      rsp.evicted_valid <= evict;
      rsp.evicted_page  <= evict ? owner_rd : '0;
      rsp.fault_count   <= hit_now ? faults : faults_inc;
    end
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    frames_used <= n_frames)
    else $error("frames in use exceed frame count");

  a_pointer_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, next_frame} < n_frames)
    else $error("round-robin pointer out of range");

  a_pointer_after_fill: assert property (@(posedge clk) disable iff (rst)
    next_frame != '0 |-> frames_used == n_frames)
    else $error("pointer moved before all frames were used");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.evicted_valid |-> !rsp.hit)
    else $error("eviction reported on a hit");

  a_lookup_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOKUP && !req.ready)
    else $error("request accepted without lookup");

endmodule

`default_nettype wire

>>> tb/tb_fifo_page_replacement.sv
`timescale 1ns / 1ps

module tb_fifo_page_replacement;
  import fpr_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } lookup_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  fpr_req_if req ();
  fpr_rsp_if rsp ();

  fifo_page_replacement DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // shadow page table
  logic [COUNT_W-1:0] frames_cfg;
  logic               resident   [VIRTUAL_PAGES];
  logic [FRAME_W-1:0] held_frame [VIRTUAL_PAGES];
  logic [PAGE_W-1:0]  owner      [MAX_FRAMES];
  int unsigned        rr_ptr;
  int unsigned        loaded;
  logic [FAULT_W-1:0] fault_tally;

  logic [PAGE_W-1:0] page_refs [$];
  lookup_t           exp_lookups [$];

  int outstanding = 0;
  int errors      = 0;
  int n_refs      = 0;
  int n_hits      = 0;
  int n_evict     = 0;
  int n_settings  = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit req_taken   = 1'b0;
  bit idle_on     = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_tables();
    for (int i = 0; i < VIRTUAL_PAGES; i++) begin
      resident[i]   = 1'b0;
      held_frame[i] = '0;
    end
    for (int i = 0; i < MAX_FRAMES; i++) owner[i] = '0;
    rr_ptr      = 0;
    loaded      = 0;
    fault_tally = '0;
  endfunction

  function automatic int unsigned usable_frames();
    if (frames_cfg == '0) return 1;
    if (frames_cfg > FRAME_COUNT_MAX) return MAX_FRAMES;
    return frames_cfg;
  endfunction

  function automatic lookup_t fifo_replace(logic [PAGE_W-1:0] pg);
    lookup_t     r;
    int unsigned n;
    r = '0;
    n = usable_frames();
    if (resident[pg]) begin
      r.hit   = 1'b1;
      r.frame = held_frame[pg];
    end else begin
      if (fault_tally != FAULT_MAX) fault_tally++;
      if (loaded < n) begin
        r.frame = FRAME_W'(loaded);
        loaded++;
      end else begin
        r.frame           = FRAME_W'(rr_ptr % n);
        r.evicted_valid   = 1'b1;
        r.evicted_page    = owner[r.frame];
        resident[r.evicted_page] = 1'b0;
        rr_ptr            = (r.frame + 1) % n;
      end
      owner[r.frame] = pg;
      resident[pg]   = 1'b1;
      held_frame[pg] = r.frame;
    end
    r.fault_count = fault_tally;
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid       <= 1'b0;
      req.page_number <= '0;
      req_taken = 1'b0;
    end else begin
      if (req.valid && !req_taken) begin
      end else if (gap_left > 0) begin
        req.valid <= 1'b0;
        gap_left--;
      end else if (page_refs.size() != 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 16);
          req.valid <= 1'b0;
        end else begin
          req.valid       <= 1'b1;
          req.page_number <= page_refs.pop_front();
        end
      end else begin
        req.valid <= 1'b0;
      end
      req_taken = 1'b0;
    end
  end

  // result back-pressure, long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // request acceptance and result checking
  always @(posedge clk) begin : monitor
    lookup_t got;
    lookup_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        exp_lookups.push_back(fifo_replace(req.page_number));
        req_taken = 1'b1;
        n_refs++;
      end
      if (rsp.valid && rsp.ready) begin
        got.hit           = rsp.hit;
        got.frame         = rsp.frame;
        got.evicted_valid = rsp.evicted_valid;
        got.evicted_page  = rsp.evicted_page;
        got.fault_count   = rsp.fault_count;
        if (exp_lookups.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing pending: hit=%0d frame=%0d ev=%0d/%0d faults=%0d",
                     $realtime, got.hit, got.frame, got.evicted_valid, got.evicted_page,
                     got.fault_count);
        end else begin
          want = exp_lookups.pop_front();
          outstanding--;
          if (want.hit) n_hits++;
          if (want.evicted_valid) n_evict++;
          if (got.hit !== want.hit || got.frame !== want.frame ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_page !== want.evicted_page ||
              got.fault_count !== want.fault_count) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch expected hit=%0d frame=%0d ev=%0d/%0d faults=%0d,",
                        " got hit=%0d frame=%0d ev=%0d/%0d faults=%0d"},
                       $realtime, want.hit, want.frame, want.evicted_valid,
                       want.evicted_page, want.fault_count, got.hit, got.frame,
                       got.evicted_valid, got.evicted_page, got.fault_count);
          end
        end
      end
    end
  end

  task automatic push_page(logic [PAGE_W-1:0] pg);
    page_refs.push_back(pg);
    outstanding++;
  endtask

  task automatic set_frames(logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frames_cfg = v;
    clear_tables();
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly a sliding working set around the frame count, the rest uniform
  task automatic queue_workload(int count);
    int unsigned       n;
    int unsigned       ws;
    int unsigned       pick;
    logic [PAGE_W-1:0] base;
    n    = usable_frames();
    base = PAGE_W'($urandom_range(0, VIRTUAL_PAGES - 1));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) base = PAGE_W'($urandom_range(0, VIRTUAL_PAGES - 1));
      ws = n + $urandom_range(0, 3);
      if (ws > 1) ws = ws - 1;
      if (ws > VIRTUAL_PAGES) ws = VIRTUAL_PAGES;
      if (pick < 72) push_page(base + PAGE_W'($urandom_range(0, ws - 1)));
      else push_page(PAGE_W'($urandom_range(0, VIRTUAL_PAGES - 1)));
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] settings [13];
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    req.valid       = 1'b0;
    req.page_number = '0;
    rsp.ready       = 1'b0;
    frames_cfg      = FRAME_COUNT_RESET;
    clear_tables();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default of four frames: fill, hit, evict in load order
    foreach (settings[i]) settings[i] = '0;
    push_page(0);  push_page(31); push_page(0);  push_page(1);
    push_page(2);  push_page(3);  push_page(31); push_page(0);
    push_page(16); push_page(15); push_page(21); push_page(10);
    wait_drained();

    // zero frames behaves as one
    set_frames(6'd0);
    push_page(5); push_page(5); push_page(6); push_page(5); push_page(31); push_page(0);
    wait_drained();

    // oversized count clamps to the maximum
    set_frames(6'd63);
    push_page(31); push_page(30); push_page(31); push_page(0); push_page(10);
    wait_drained();

    settings[0]  = 6'd32;
    settings[1]  = 6'd1;
    settings[2]  = 6'd2;
    settings[3]  = 6'd33;
    settings[4]  = 6'd63;
    settings[5]  = 6'd0;
    settings[6]  = 6'd17;
    settings[7]  = 6'd4;
    settings[8]  = COUNT_W'($urandom_range(1, 32));
    settings[9]  = COUNT_W'($urandom_range(0, 63));
    settings[10] = COUNT_W'($urandom_range(1, 8));
    settings[11] = COUNT_W'($urandom_range(0, 63));
    settings[12] = 6'd31;

    foreach (settings[i]) begin
      set_frames(settings[i]);
      @(posedge clk);
      idle_on = (i % 4 != 3);
      queue_workload(145);
      if (i == 0) begin
        // sender keeps offering while results are held back
        @(posedge clk);
        hold_left = 200;
      end
      wait_drained();
    end

    // alternating pages miss on one frame, then a repeated page hits; no idling at the end
    set_frames(6'd1);
    @(posedge clk);
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++) push_page((i % 2 == 0) ? PAGE_W'(7) : PAGE_W'(24));
    push_page(24);
    push_page(7);
    push_page(7);
    wait_drained();

    errors += exp_lookups.size();
    $display("%0d page references over %0d frame-count settings: %0d hits, %0d evictions",
             n_refs, n_settings, n_hits, n_evict);
    $display("ended with a back-to-back one-frame thrash; %0d errors recorded", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/fpr_pkg.sv
rtl/fpr_req_if.sv
rtl/fpr_rsp_if.sv
rtl/fifo_page_replacement.sv
tb/tb_fifo_page_replacement.sv
